### rtl/core/gtg_pkg.sv
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared constants, widths, command/status structs and tables for the
// go-to-goal wheel speed controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

    localparam int COORD_BITS_DEF   = 12;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX       = 24;

    // Fine CORDIC angle: units of 2^-24 rad
    localparam int ZW = 28;
    localparam logic signed [ZW-1:0] PI_FINE = 28'sd52707179;
    localparam logic signed [17:0] WRAP_LIM  = 18'sd12861;
    localparam logic signed [17:0] WRAP_STEP = 18'sd25723;

    // Configuration register indexes
    localparam logic [2:0] REG_DIST_GAIN = 3'd0;
    localparam logic [2:0] REG_P_GAIN    = 3'd1;
    localparam logic [2:0] REG_D_GAIN    = 3'd2;
    localparam logic [2:0] REG_APPROACH  = 3'd3;
    localparam logic [2:0] REG_PRES_LIM  = 3'd4;
    localparam logic [2:0] REG_ABS_LIM   = 3'd5;

    localparam int CFG_W = 16;

    // Datapath commands
    typedef struct packed {
        logic load;     // capture input item, init CORDIC and isqrt
        logic iter;     // one CORDIC and one root step
        logic err;      // form heading error / turn term
        logic mul_p;    // proportional product
        logic mul_d;    // derivative product, base
        logic sum;      // sums, rounding, result register
    } gtg_cmd_t;

    typedef struct packed {
        logic busy;
    } gtg_stat_t;

    function automatic logic signed [ZW-1:0] atan_fine(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                5'd0:  r = 28'sd13176795;
                5'd1:  r = 28'sd7778716;
                5'd2:  r = 28'sd4110060;
                5'd3:  r = 28'sd2086331;
                5'd4:  r = 28'sd1047214;
                5'd5:  r = 28'sd524117;
                5'd6:  r = 28'sd262123;
                5'd7:  r = 28'sd131069;
                default: r = ZW'(28'sd65536 >>> (i - 5'd8));
            endcase
            atan_fine = r;
        end
    endfunction

endpackage

### rtl/core/go_to_goal_wheel_speed.sv
// ----------------------------------------------------------------------------
// go_to_goal_wheel_speed
// Differential-drive go-to-goal PD controller with CORDIC bearing.
// ----------------------------------------------------------------------------
// Sequence per item: load, the shared CORDIC / root iteration loop, error,
//   proportional and derivative products, sum, then output handoff, which
//   waits while the output is held; one item in flight at a time.
// Reset: asynchronous, active low; registers take their reset values,
//   error history and presence counter clear to zero.
module go_to_goal_wheel_speed #(
    parameter int COORD_BITS   = gtg_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    // {target_angle, target_y, target_x, robot_heading, robot_y, robot_x, opcode}
    input  logic [79:0]  s_tdata,
    input  logic         s_tuser,   // pose_valid
    input  logic         s_tvalid,
    output logic         s_tready,
    // {robot_present, angle_error, distance, right_speed, left_speed}
    output logic [63:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int RS    = COORD_BITS + 1;
    localparam int ITERS = (CORDIC_STEPS > RS) ? CORDIC_STEPS : RS;

    logic [15:0] dist_gain_reg, p_gain_reg, d_gain_reg;
    logic [12:0] appr_reg;
    logic [3:0]  pres_lim_reg, abs_lim_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_gain_reg <= 16'd115;
            p_gain_reg    <= 16'd2867;
            d_gain_reg    <= 16'd4096;
            appr_reg      <= 13'd400;
            pres_lim_reg  <= 4'd2;
            abs_lim_reg   <= 4'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gtg_pkg::REG_DIST_GAIN: dist_gain_reg <= cfg_data;
                gtg_pkg::REG_P_GAIN:    p_gain_reg    <= cfg_data;
                gtg_pkg::REG_D_GAIN:    d_gain_reg    <= cfg_data;
                gtg_pkg::REG_APPROACH:  appr_reg      <= cfg_data[12:0];
                gtg_pkg::REG_PRES_LIM:  pres_lim_reg  <= cfg_data[3:0];
                gtg_pkg::REG_ABS_LIM:   abs_lim_reg   <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    gtg_pkg::gtg_cmd_t cmd;
    logic idle, done, mvalid_reg;
    logic signed [15:0] ls, rs, ae;
    logic [12:0] dist_mm;
    logic pres;

    assign s_tready = idle;

    gtg_ctrl #(.ITERS(ITERS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .start(s_tvalid),
        .out_free(!mvalid_reg || m_tready),
        .cmd(cmd), .idle(idle), .done(done)
    );

    gtg_dp #(.CB(COORD_BITS), .STEPS(CORDIC_STEPS), .ITERS(ITERS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_opcode(s_tdata[0]),
        .in_rx(COORD_BITS'(s_tdata[12:1])),
        .in_ry(COORD_BITS'(s_tdata[24:13])),
        .in_heading(s_tdata[38:25]),
        .in_valid(s_tuser),
        .in_tx(COORD_BITS'(s_tdata[50:39])),
        .in_ty(COORD_BITS'(s_tdata[62:51])),
        .in_tang(s_tdata[78:63]),
        .dist_gain(dist_gain_reg), .p_gain(p_gain_reg), .d_gain(d_gain_reg),
        .appr_dist(appr_reg), .pres_lim(pres_lim_reg), .abs_lim(abs_lim_reg),
        .left_speed(ls), .right_speed(rs), .distance(dist_mm),
        .angle_error(ae), .robot_present(pres)
    );

    // Output stage
    logic [63:0] mdata_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mvalid_reg <= 1'b0;
        else if (done)
            mvalid_reg <= 1'b1;
        else if (m_tready)
            mvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            mdata_reg <= {2'd0, pres, ae, dist_mm, rs, ls};
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

### rtl/core/gtg_ctrl.sv
// ----------------------------------------------------------------------------
// gtg_ctrl
// Sequencer: load, CORDIC/root iterations, error, two products, sum, output handoff.
// ----------------------------------------------------------------------------
module gtg_ctrl #(
    parameter int ITERS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             out_free,
    output gtg_pkg::gtg_cmd_t cmd,
    output logic             idle,
    output logic             done
);

    typedef enum logic [2:0] {S_IDLE, S_ITER, S_ERR, S_MULP, S_MULD, S_SUM, S_OUT} state_t;

    localparam int CW = $clog2(ITERS + 1);

    state_t         state_reg;
    logic [CW-1:0]  cnt_reg;

    assign idle = (state_reg == S_IDLE);

    // Command decode
    always_comb
    begin
        cmd      = '0;
        cmd.load = idle && start;
        cmd.iter = (state_reg == S_ITER);
        cmd.err  = (state_reg == S_ERR);
        cmd.mul_p = (state_reg == S_MULP);
        cmd.mul_d = (state_reg == S_MULD);
        cmd.sum  = (state_reg == S_SUM);
        done     = (state_reg == S_OUT) && out_free;
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_ITER;
                        cnt_reg   <= '0;
                    end
                end
                S_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(ITERS - 1))
                        state_reg <= S_ERR;
                end
                S_ERR:  state_reg <= S_MULP;
                S_MULP: state_reg <= S_MULD;
                S_MULD: state_reg <= S_SUM;
                S_SUM:  state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/gtg_dp.sv
// ----------------------------------------------------------------------------
// gtg_dp
// Datapath: vectoring CORDIC, bit-serial integer root, heading error state,
// presence counter, PD products and saturated wheel speeds.
// ----------------------------------------------------------------------------
module gtg_dp #(
    parameter int CB    = gtg_pkg::COORD_BITS_DEF,
    parameter int STEPS = gtg_pkg::CORDIC_STEPS_DEF,
    parameter int ITERS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gtg_pkg::gtg_cmd_t       cmd,
    input  logic                    in_opcode,
    input  logic [CB-1:0]           in_rx,
    input  logic [CB-1:0]           in_ry,
    input  logic signed [13:0]      in_heading,
    input  logic                    in_valid,
    input  logic [CB-1:0]           in_tx,
    input  logic [CB-1:0]           in_ty,
    input  logic signed [15:0]      in_tang,
    input  logic [15:0]             dist_gain,
    input  logic [15:0]             p_gain,
    input  logic [15:0]             d_gain,
    input  logic [12:0]             appr_dist,
    input  logic [3:0]              pres_lim,
    input  logic [3:0]              abs_lim,
    output logic signed [15:0]      left_speed,
    output logic signed [15:0]      right_speed,
    output logic [12:0]             distance,
    output logic signed [15:0]      angle_error,
    output logic                    robot_present
);

    localparam int DW  = CB + 1;             // signed difference
    localparam int XW  = DW + 14;            // CORDIC x/y with gain growth
    localparam int SQW = 2 * CB + 2;         // squared distance
    localparam int RW  = CB + 2;             // root width
    localparam int NW  = (SQW > 26) ? SQW : 26;  // near-zone compare width
    localparam int RSTEPS = SQW / 2;
    localparam int NS  = (STEPS < gtg_pkg::CORDIC_MAX) ? STEPS : gtg_pkg::CORDIC_MAX;
    localparam int IW  = $clog2(ITERS + 1);
    localparam int ZW  = gtg_pkg::ZW;

    // Item registers
    logic                   turn_reg;
    logic signed [17:0]     theta_reg;
    logic signed [15:0]     tang_reg;
    logic                   zero_vec_reg;
    logic [IW-1:0]          it_reg;
    logic signed [XW-1:0]   x_reg, y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic [SQW-1:0]         rem_reg, sq_reg;
    logic [SQW-1:0]         root_reg;
    logic signed [17:0]     err_reg;
    logic signed [17:0]     prev_err_reg, chg_reg;
    logic signed [4:0]      pcnt_reg;
    logic signed [35:0]     pterm_reg, dterm_reg;
    logic signed [37:0]     base_reg;
    logic                   near_reg;
    logic signed [15:0]     ls_reg, rs_reg, ae_reg;
    logic [12:0]            dist_reg;
    logic                   pres_reg;

    // Input decode
    logic signed [DW-1:0]   dx, dy;
    logic [13:0]            hmag;
    logic [25:0]            hnum;
    logic [17:0]            hq;
    logic signed [17:0]     theta_c;
    logic [SQW-1:0]         dsq;

    always_comb
    begin
        dx   = $signed({1'b0, in_tx}) - $signed({1'b0, in_rx});
        dy   = $signed({1'b0, in_ty}) - $signed({1'b0, in_ry});
        hmag = in_heading[13] ? -in_heading : in_heading;
        hnum = 26'(hmag) * 26'd4096 + 26'd500;
        // divide by 1000: reciprocal multiply, exact for this range
        hq   = 18'((54'(hnum) * 54'd68719477) >> 36);
        theta_c = in_heading[13] ? -$signed(hq) : $signed(hq);
        dsq  = SQW'(dx * dx) + SQW'(dy * dy);
    end

    // CORDIC step
    logic [4:0]            idx;
    logic signed [XW-1:0]  xs, ys;
    assign idx = 5'(it_reg);
    assign xs  = x_reg >>> idx;
    assign ys  = y_reg >>> idx;

    // Root step
    logic [IW-1:0]   ridx;
    logic [SQW-1:0]  rbit, rtry;
    logic [RW-1:0]   root_val;
    assign ridx = IW'(RSTEPS - 1) - it_reg;
    assign rbit = SQW'(1) << (2 * ridx);
    assign rtry = root_reg + rbit;
    assign root_val = RW'(root_reg);

    // Error and sum
    logic signed [17:0]     e_raw, e_wrap, err_sel;
    logic signed [ZW:0]     zr;
    logic signed [39:0]     sum_r, sum_l;
    logic signed [28:0]     sh_r, sh_l;

    always_comb
    begin
        zr     = (z_reg + (ZW+1)'(2048)) >>> 12;
        e_raw  = (zero_vec_reg ? 18'sd0 : 18'(zr)) - theta_reg;
        if (e_raw > gtg_pkg::WRAP_LIM)       e_wrap = e_raw - gtg_pkg::WRAP_STEP;
        else if (e_raw < -gtg_pkg::WRAP_LIM) e_wrap = e_raw + gtg_pkg::WRAP_STEP;
        else                                  e_wrap = e_raw;
        err_sel = turn_reg ? (theta_reg + 18'(tang_reg)) : e_wrap;
        sum_r  = 40'(base_reg) + 40'(pterm_reg) + 40'(dterm_reg) + 40'sd1024;
        sum_l  = 40'(base_reg) - 40'(pterm_reg) + 40'(dterm_reg) + 40'sd1024;
        sh_r   = 29'(sum_r >>> 11);
        sh_l   = 29'(sum_l >>> 11);
    end

    function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
        begin
            if (v > 29'sd32767)       sat16 = 16'sh7FFF;
            else if (v < -29'sd32768) sat16 = 16'sh8000;
            else                      sat16 = 16'(v);
        end
    endfunction

    // Control state: error history and presence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            chg_reg      <= '0;
            pcnt_reg     <= '0;
        end
        else
        begin
            if (cmd.err && !turn_reg)
            begin
                chg_reg      <= e_raw - prev_err_reg;
                prev_err_reg <= e_raw;
            end
            if (cmd.load)
            begin
                if (in_valid && pcnt_reg < $signed({1'b0, pres_lim}))
                    pcnt_reg <= pcnt_reg + 5'sd1;
                else if (!in_valid && pcnt_reg > -$signed({1'b0, abs_lim}))
                    pcnt_reg <= pcnt_reg - 5'sd1;
            end
        end
    end

    // Payload datapath
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            turn_reg     <= in_opcode;
            theta_reg    <= theta_c;
            tang_reg     <= in_tang;
            zero_vec_reg <= (dx == '0) && (dy == '0);
            it_reg       <= '0;
            sq_reg       <= dsq;
            rem_reg      <= dsq;
            root_reg     <= '0;
            if (dx < 0)
            begin
                x_reg <= -(XW'(dx) <<< 12);
                y_reg <= -(XW'(dy) <<< 12);
                z_reg <= (dy >= 0) ? gtg_pkg::PI_FINE : -gtg_pkg::PI_FINE;
            end
            else
            begin
                x_reg <= XW'(dx) <<< 12;
                y_reg <= XW'(dy) <<< 12;
                z_reg <= '0;
            end
        end
        if (cmd.iter)
        begin
            it_reg <= it_reg + 1'b1;
            if (32'(it_reg) < NS)
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + gtg_pkg::atan_fine(idx);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - gtg_pkg::atan_fine(idx);
                end
            end
            if (32'(it_reg) < RSTEPS)
            begin
                // partial root runs wider than the final root
                if (rem_reg >= rtry)
                begin
                    rem_reg  <= rem_reg - rtry;
                    root_reg <= (root_reg >> 1) + rbit;
                end
                else
                    root_reg <= root_reg >> 1;
            end
        end
        if (cmd.err)
        begin
            err_reg  <= err_sel;
            near_reg <= !(NW'(sq_reg) > NW'(appr_dist) * NW'(appr_dist));
        end
        if (cmd.mul_p)
            pterm_reg <= 36'($signed({1'b0, p_gain}) * err_reg);
        if (cmd.mul_d)
        begin
            dterm_reg <= 36'($signed({1'b0, d_gain}) * chg_reg);
            if (turn_reg || !near_reg)
                base_reg <= 38'sd16777216;
            else
                base_reg <= $signed({1'b0, 37'(dist_gain * root_val) << 8});
        end
        if (cmd.sum)
        begin
            pres_reg <= (pcnt_reg >= 0);
            ls_reg   <= (pcnt_reg >= 0) ? sat16(sh_l) : 16'sd0;
            rs_reg   <= (pcnt_reg >= 0) ? sat16(sh_r) : 16'sd0;
            ae_reg   <= sat16(29'(err_reg));
            dist_reg <= turn_reg ? 13'd0 :
                        ((32'(root_val) > 8191) ? 13'd8191 : 13'(root_val));
        end
    end

    assign left_speed    = ls_reg;
    assign right_speed   = rs_reg;
    assign distance      = dist_reg;
    assign angle_error   = ae_reg;
    assign robot_present = pres_reg;

endmodule

### rtl/core/gtg_checker.sv
// ----------------------------------------------------------------------------
// gtg_checker
// Port-level checks for the go-to-goal controller, bound to the top level.
// ----------------------------------------------------------------------------
module gtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // One item in flight: no accept right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accept right after accept");

    // Speeds are zero when robot not present
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[61] |-> m_tdata[31:0] == 32'd0)
        else $error("nonzero speed while absent");

    // Held result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");

    // No result right after accept
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

endmodule

bind go_to_goal_wheel_speed gtg_checker u_gtg_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
